// ----- hdl/sfla_pkg.sv -----
`default_nettype none
package sfla_pkg;

    localparam int ADDR_W   = 12;
    localparam int STATUS_W = 2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_HEAP_OUT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LIST_FULL = 2'd2;

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_FIT   = 2'd0;  // first entry with size >= key
    localparam mode_t MODE_MATCH = 2'd1;  // first entry with offset == key
    localparam mode_t MODE_INS   = 2'd2;  // insert point: empty or size >= key
    localparam mode_t MODE_ADJ   = 2'd3;  // first entry that ends at key

    typedef logic [1:0] act_t;
    localparam act_t ACT_NONE   = 2'd0;
    localparam act_t ACT_REMOVE = 2'd1;
    localparam act_t ACT_INSERT = 2'd2;

    typedef struct packed {
        mode_t mode;
        act_t  act;
    } cell_cmd_t;

endpackage
`default_nettype wire

// ----- hdl/sfla_cell.sv -----
`default_nettype none
module sfla_cell
    import sfla_pkg::*;
#(
    parameter int AW  = 12,
    parameter int KW  = 14,
    parameter int HDR = 16
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cell_cmd_t     cmd,
    input  wire logic [KW-1:0] key,
    input  wire logic [AW-1:0] new_h,
    input  wire logic [AW-1:0] new_size,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [AW-1:0] wr_size,
    input  wire logic          pred_valid,
    input  wire logic [AW-1:0] pred_h,
    input  wire logic [AW-1:0] pred_size,
    input  wire logic          succ_valid,
    input  wire logic [AW-1:0] succ_h,
    input  wire logic [AW-1:0] succ_size,
    input  wire logic          scan_in_found,
    input  wire logic [AW-1:0] scan_in_h,
    input  wire logic [AW-1:0] scan_in_size,
    output logic               valid,
    output logic [AW-1:0]      h,
    output logic [AW-1:0]      size,
    output logic               scan_out_found,
    output logic [AW-1:0]      scan_out_h,
    output logic [AW-1:0]      scan_out_size
);

    logic          valid_reg;
    logic [AW-1:0] h_reg;
    logic [AW-1:0] size_reg;
    logic          found_reg;
    logic [AW-1:0] fh_reg;
    logic [AW-1:0] fsize_reg;
    logic          hit;
    logic          first;
    logic          after;
    logic          ld_succ;
    logic          ld_new;
    logic          ld_pred;
    logic          upd;
    logic [KW-1:0] end_off;

    assign end_off = KW'(h_reg) + KW'(HDR) + KW'(size_reg);

    always_comb
    begin
        unique case (cmd.mode)
            MODE_FIT:   hit = valid_reg && (KW'(size_reg) >= key);
            MODE_MATCH: hit = valid_reg && (KW'(h_reg) == key);
            MODE_INS:   hit = !valid_reg || (KW'(size_reg) >= key);
            MODE_ADJ:   hit = valid_reg && (end_off == key);
            default:    hit = 1'b0;
        endcase
    end

    assign after   = scan_in_found;
    assign first   = hit && !scan_in_found;
    assign ld_succ = (cmd.act == ACT_REMOVE) && (first || after);
    assign ld_new  = (cmd.act == ACT_INSERT) && first;
    assign ld_pred = (cmd.act == ACT_INSERT) && after;
    assign upd     = wr_en && valid_reg && (h_reg == wr_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (ld_succ)
                valid_reg <= succ_valid;
            else if (ld_new)
                valid_reg <= 1'b1;
            else if (ld_pred)
                valid_reg <= pred_valid;
            found_reg <= scan_in_found || hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_succ)
        begin
            h_reg    <= succ_h;
            size_reg <= succ_size;
        end
        else if (ld_new)
        begin
            h_reg    <= new_h;
            size_reg <= new_size;
        end
        else if (ld_pred)
        begin
            h_reg    <= pred_h;
            size_reg <= pred_size;
        end
        else if (upd)
            size_reg <= wr_size;
        // carry the first hit down the chain
        if (scan_in_found)
        begin
            fh_reg    <= scan_in_h;
            fsize_reg <= scan_in_size;
        end
        else
        begin
            fh_reg    <= h_reg;
            fsize_reg <= size_reg;
        end
    end

    assign valid          = valid_reg;
    assign h              = h_reg;
    assign size           = size_reg;
    assign scan_out_found = found_reg;
    assign scan_out_h     = fh_reg;
    assign scan_out_size  = fsize_reg;

endmodule
`default_nettype wire

// ----- hdl/sorted_free_list_allocator.sv -----
`default_nettype none
// Heap allocator with a size-ordered free list and coalescing. Each item is an
// allocate (tuser 0) or a free (tuser 1) and yields exactly one result item.
// The free list lives in a chain of FREE_ENTRIES cells; every list query
// (first fit, lookup by offset, insert point, adjacent predecessor) is a scan
// whose first hit ripples one cell per cycle down all FREE_ENTRIES cells.
// Removes and inserts then shift every cell of the chain together. Block
// sizes are kept in a HEAP_BYTES-deep header RAM, mirrored into the cells.
// Allocate: one scan, two when the block is split. Free: up to five scans.
// A new item is taken while the previous result waits at the output.
module sorted_free_list_allocator
    import sfla_pkg::*;
#(
    parameter int HEAP_BYTES   = 4096,
    parameter int HEADER_BYTES = 16,
    parameter int FREE_ENTRIES = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // request_bytes[11:0], release_address[23:12]
    input  wire logic        s_axis_tuser,   // opcode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // payload_address[11:0], status[13:12], zero pad
);

    localparam int AW   = $clog2(HEAP_BYTES);
    localparam int KW   = ((AW > ADDR_W) ? AW : ADDR_W) + 2;
    localparam int CW   = $clog2(FREE_ENTRIES + 1);
    localparam int SW   = (FREE_ENTRIES > 2) ? $clog2(FREE_ENTRIES) : 1;
    localparam int N    = FREE_ENTRIES;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_A_FIT = 4'd2;
    localparam logic [3:0] S_A_WH  = 4'd3;
    localparam logic [3:0] S_A_INS = 4'd4;
    localparam logic [3:0] S_A_WT  = 4'd5;
    localparam logic [3:0] S_F_CHK = 4'd6;
    localparam logic [3:0] S_F_NX  = 4'd7;
    localparam logic [3:0] S_F_WH  = 4'd8;
    localparam logic [3:0] S_F_INS = 4'd9;
    localparam logic [3:0] S_F_ADJ = 4'd10;
    localparam logic [3:0] S_F_RM  = 4'd11;
    localparam logic [3:0] S_F_WP  = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    logic [3:0]          state_reg, state_next;
    logic [3:0]          ret_reg, ret_next;
    logic [SW-1:0]       cnt_reg, cnt_next;
    mode_t               mode_reg, mode_next;
    logic [KW-1:0]       key_reg, key_next;
    logic [AW:0]         bump_reg, bump_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [ADDR_W-1:0]   req_reg, req_next;
    logic [AW-1:0]       h_reg, h_next;
    logic [AW-1:0]       sz_reg, sz_next;
    logic [AW-1:0]       blk_reg, blk_next;
    logic [AW-1:0]       tail_reg, tail_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;
    logic [STATUS_W-1:0] res_st_reg, res_st_next;
    logic                m_valid_reg, m_valid_next;
    logic [15:0]         m_data_reg, m_data_next;

    act_t                act;
    cell_cmd_t           cmd;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       wr_size;
    logic [AW-1:0]       mem [0:HEAP_BYTES-1];
    logic [AW-1:0]       rd_data_reg;

    logic                c_valid [N];
    logic [AW-1:0]       c_h     [N];
    logic [AW-1:0]       c_size  [N];
    logic                sc_found [N];
    logic [AW-1:0]       sc_h     [N];
    logic [AW-1:0]       sc_size  [N];
    logic                res_found;
    logic [AW-1:0]       res_h;
    logic [AW-1:0]       res_size;

    logic [ADDR_W-1:0]   in_req;
    logic [ADDR_W-1:0]   in_rel;
    logic [KW-1:0]       rel_h;
    logic [KW-1:0]       need;
    logic [KW-1:0]       head;
    logic [KW-1:0]       next_off;
    logic [KW-1:0]       bump_end;

    assign in_req = s_axis_tdata[11:0];
    assign in_rel = s_axis_tdata[23:12];
    assign rel_h  = KW'(in_rel) - KW'(HEADER_BYTES);

    assign res_found = sc_found[N-1];
    assign res_h     = sc_h[N-1];
    assign res_size  = sc_size[N-1];

    assign need     = KW'(req_reg) + KW'(HEADER_BYTES);
    assign head     = KW'(res_size) - need;
    assign next_off = KW'(h_reg) + KW'(HEADER_BYTES) + KW'(rd_data_reg);
    assign bump_end = KW'(bump_reg) + KW'(HEADER_BYTES);

    assign cmd.mode = mode_reg;
    assign cmd.act  = act;

    // header RAM, also mirrored into any cell holding the written offset
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_size;
        rd_data_reg <= mem[h_reg];
    end

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            logic          pv;
            logic [AW-1:0] ph;
            logic [AW-1:0] ps;
            logic          nv;
            logic [AW-1:0] nh;
            logic [AW-1:0] ns;
            logic          sf;
            logic [AW-1:0] sh;
            logic [AW-1:0] ss;
            if (gi == 0)
            begin : g_head
                assign pv = 1'b0;
                assign ph = '0;
                assign ps = '0;
                assign sf = 1'b0;
                assign sh = '0;
                assign ss = '0;
            end
            else
            begin : g_mid
                assign pv = c_valid[gi-1];
                assign ph = c_h[gi-1];
                assign ps = c_size[gi-1];
                assign sf = sc_found[gi-1];
                assign sh = sc_h[gi-1];
                assign ss = sc_size[gi-1];
            end
            if (gi == N - 1)
            begin : g_tail
                assign nv = 1'b0;
                assign nh = '0;
                assign ns = '0;
            end
            else
            begin : g_body
                assign nv = c_valid[gi+1];
                assign nh = c_h[gi+1];
                assign ns = c_size[gi+1];
            end
            sfla_cell #(
                .AW  (AW),
                .KW  (KW),
                .HDR (HEADER_BYTES)
            ) u_cell (
                .clk            (clk),
                .rst_n          (rst_n),
                .cmd            (cmd),
                .key            (key_reg),
                .new_h          (h_reg),
                .new_size       (sz_reg),
                .wr_en          (wr_en),
                .wr_addr        (wr_addr),
                .wr_size        (wr_size),
                .pred_valid     (pv),
                .pred_h         (ph),
                .pred_size      (ps),
                .succ_valid     (nv),
                .succ_h         (nh),
                .succ_size      (ns),
                .scan_in_found  (sf),
                .scan_in_h      (sh),
                .scan_in_size   (ss),
                .valid          (c_valid[gi]),
                .h              (c_h[gi]),
                .size           (c_size[gi]),
                .scan_out_found (sc_found[gi]),
                .scan_out_h     (sc_h[gi]),
                .scan_out_size  (sc_size[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        cnt_next      = cnt_reg;
        mode_next     = mode_reg;
        key_next      = key_reg;
        bump_next     = bump_reg;
        count_next    = count_reg;
        req_next      = req_reg;
        h_next        = h_reg;
        sz_next       = sz_reg;
        blk_next      = blk_reg;
        tail_next     = tail_reg;
        res_addr_next = res_addr_reg;
        res_st_next   = res_st_reg;
        act           = ACT_NONE;
        wr_en         = 1'b0;
        wr_addr       = h_reg;
        wr_size       = sz_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    req_next      = in_req;
                    res_addr_next = '0;
                    res_st_next   = ST_DONE;
                    cnt_next      = '0;
                    if (s_axis_tuser == OP_ALLOC)
                    begin
                        mode_next  = MODE_FIT;
                        key_next   = KW'(in_req);
                        ret_next   = S_A_FIT;
                        state_next = S_SCAN;
                    end
                    else if (KW'(in_rel) < KW'(HEADER_BYTES) || rel_h >= KW'(bump_reg))
                        state_next = S_OUT;     // null or out-of-range free
                    else
                    begin
                        h_next     = AW'(rel_h);
                        mode_next  = MODE_MATCH;
                        key_next   = rel_h;
                        ret_next   = S_F_CHK;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SW'(N - 1))
                    state_next = ret_reg;
            end
            S_A_FIT:
            begin
                if (res_found)
                begin
                    act        = ACT_REMOVE;
                    count_next = count_reg - 1'b1;
                    blk_next   = res_h;
                    if (KW'(res_size) > need)
                    begin
                        // split: head stays free, tail is handed out
                        sz_next    = AW'(head);
                        tail_next  = AW'(KW'(res_h) + KW'(HEADER_BYTES) + head);
                        state_next = S_A_WH;
                    end
                    else
                    begin
                        res_addr_next = ADDR_W'(KW'(res_h) + KW'(HEADER_BYTES));
                        state_next    = S_OUT;
                    end
                end
                else if (bump_end + KW'(req_reg) > KW'(HEAP_BYTES) ||
                         bump_end >= KW'(HEAP_BYTES))
                begin
                    res_st_next = ST_HEAP_OUT;
                    state_next  = S_OUT;
                end
                else
                begin
                    wr_en         = 1'b1;
                    wr_addr       = AW'(bump_reg);
                    wr_size       = AW'(req_reg);
                    res_addr_next = ADDR_W'(bump_end);
                    bump_next     = (AW+1)'(bump_end + KW'(req_reg));
                    state_next    = S_OUT;
                end
            end
            S_A_WH:
            begin
                wr_en      = 1'b1;
                wr_addr    = blk_reg;
                h_next     = blk_reg;
                mode_next  = MODE_INS;
                key_next   = KW'(sz_reg);
                cnt_next   = '0;
                ret_next   = S_A_INS;
                state_next = S_SCAN;
            end
            S_A_INS:
            begin
                act        = ACT_INSERT;
                count_next = count_reg + 1'b1;
                state_next = S_A_WT;
            end
            S_A_WT:
            begin
                wr_en         = 1'b1;
                wr_addr       = tail_reg;
                wr_size       = AW'(req_reg);
                res_addr_next = ADDR_W'(KW'(tail_reg) + KW'(HEADER_BYTES));
                state_next    = S_OUT;
            end
            S_F_CHK:
            begin
                if (res_found)
                    state_next = S_OUT;         // already free
                else
                begin
                    sz_next = rd_data_reg;
                    if (next_off != KW'(bump_reg))
                    begin
                        mode_next  = MODE_MATCH;
                        key_next   = next_off;
                        cnt_next   = '0;
                        ret_next   = S_F_NX;
                        state_next = S_SCAN;
                    end
                    else
                        state_next = S_F_NX;    // scan result still "not found"
                end
            end
            S_F_NX:
            begin
                if (res_found)
                begin
                    act        = ACT_REMOVE;
                    count_next = count_reg - 1'b1;
                    sz_next    = AW'(KW'(sz_reg) + KW'(HEADER_BYTES) + KW'(res_size));
                    state_next = S_F_WH;
                end
                else if (count_reg >= CW'(N))
                begin
                    res_st_next = ST_LIST_FULL;
                    state_next  = S_OUT;
                end
                else
                    state_next = S_F_WH;
            end
            S_F_WH:
            begin
                wr_en      = 1'b1;
                mode_next  = MODE_INS;
                key_next   = KW'(sz_reg);
                cnt_next   = '0;
                ret_next   = S_F_INS;
                state_next = S_SCAN;
            end
            S_F_INS:
            begin
                act        = ACT_INSERT;
                count_next = count_reg + 1'b1;
                mode_next  = MODE_ADJ;
                key_next   = KW'(h_reg);
                cnt_next   = '0;
                ret_next   = S_F_ADJ;
                state_next = S_SCAN;
            end
            S_F_ADJ:
            begin
                if (res_found)
                begin
                    // predecessor ends where this block starts
                    blk_next   = res_h;
                    tail_next  = res_size;
                    mode_next  = MODE_MATCH;
                    key_next   = KW'(h_reg);
                    cnt_next   = '0;
                    ret_next   = S_F_RM;
                    state_next = S_SCAN;
                end
                else
                    state_next = S_OUT;
            end
            S_F_RM:
            begin
                if (res_found)
                begin
                    act        = ACT_REMOVE;
                    count_next = count_reg - 1'b1;
                end
                sz_next    = AW'(KW'(tail_reg) + KW'(HEADER_BYTES) + KW'(sz_reg));
                state_next = S_F_WP;
            end
            S_F_WP:
            begin
                wr_en      = 1'b1;
                wr_addr    = blk_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // output register: loaded when a result leaves S_OUT
    always_comb
    begin
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        if (state_reg == S_OUT && (!m_valid_reg || m_axis_tready))
        begin
            m_valid_next = 1'b1;
            m_data_next  = {2'b00, res_st_reg, res_addr_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            mode_reg    <= MODE_FIT;
            bump_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            ret_reg     <= S_IDLE;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            mode_reg    <= mode_next;
            bump_reg    <= bump_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            ret_reg     <= ret_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        req_reg      <= req_next;
        h_reg        <= h_next;
        sz_reg       <= sz_next;
        blk_reg      <= blk_next;
        tail_reg     <= tail_next;
        res_addr_reg <= res_addr_next;
        res_st_reg   <= res_st_next;
        m_data_reg   <= m_data_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule
`default_nettype wire
